[sv/u8san_pkg.sv]
`timescale 1ns / 1ps

package u8san_pkg;

    // Replacement string storage and default cap on its length
    localparam int REPL_REG_BYTES      = 4;
    localparam int MAX_REPL_BYTES_DEF  = 4;
    localparam int SUBST_LEN_W         = 3;
    localparam int CFG_DATA_W          = 32;
    localparam int CFG_IDX_W           = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REPL_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBST_LEN  = 2'd1;

    // Sequence buffering: five held bytes plus the closing byte
    localparam int PEND_DEPTH  = 5;
    localparam int PEND_IDX_W  = 3;
    localparam int SEQ_BYTES   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Work handed from the classifier to the emitter:
    // optional replacement, a run of literal bytes, optional replacement
    typedef struct packed {
        logic                      pre_repl;
        logic [2:0]                n_bytes;
        logic [SEQ_BYTES-1:0][7:0] bytes;
        logic                      post_repl;
    } job_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_BODY,
        PH_POST
    } phase_t;

    // Sequence width from the lead byte, zero for a follow byte or 0xFE/0xFF
    function automatic logic [2:0] lead_width(input logic [7:0] b);
        logic [2:0] w;
        priority if (b <= 8'h7f) w = 3'd1;
        else if (b <= 8'hbf)     w = 3'd0;
        else if (b <= 8'hdf)     w = 3'd2;
        else if (b <= 8'hef)     w = 3'd3;
        else if (b <= 8'hf7)     w = 3'd4;
        else if (b <= 8'hfb)     w = 3'd5;
        else if (b <= 8'hfd)     w = 3'd6;
        else                     w = 3'd0;
        return w;
    endfunction

endpackage

[sv/utf8_sanitizer_with_replacement_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data  (data_byte, end_of_text)
// out       output     out_valid / out_stall out_data (out_byte, last_of_run)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A byte is accepted whenever the two-entry work queue has room; each input
// transaction then yields zero to eight output bytes, sent by the emitter one per
// cycle while out_stall is low, so the sustained rate is set by its one-byte port.
// Reset clears the sequence state, the queue, the output valid and both
// configuration registers. in_stall follows the queue being full; out_stall
// holds the output register and, through the queue, backs up to the input.

module utf8_sanitizer_with_replacement_top
    import u8san_pkg::*;
#(
    parameter int MAX_REPL_BYTES = MAX_REPL_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int REPL_CAP = (MAX_REPL_BYTES < REPL_REG_BYTES) ?
                              MAX_REPL_BYTES : REPL_REG_BYTES;

    logic [CFG_DATA_W-1:0]  repl_bytes_reg;
    logic [SUBST_LEN_W-1:0] subst_len_reg;
    logic [SUBST_LEN_W-1:0] subst_len_eff;

    logic q_push, q_full, q_pop, q_head_valid;
    job_t q_in_job, q_head_job;

    assign cfg_ready     = 1'b1;
    assign subst_len_eff = (subst_len_reg > SUBST_LEN_W'(REPL_CAP)) ?
                           SUBST_LEN_W'(REPL_CAP) : subst_len_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_bytes_reg <= '0;
            subst_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REPL_BYTES: repl_bytes_reg <= cfg_data;
                REG_SUBST_LEN:  subst_len_reg  <= cfg_data[SUBST_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    u8san_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .subst_len (subst_len_eff),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_in_job)
    );

    u8san_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop)
    );

    u8san_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .repl_bytes (repl_bytes_reg),
        .subst_len  (subst_len_eff),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

[sv/u8san_front.sv]
`timescale 1ns / 1ps

module u8san_front
    import u8san_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    input  logic [SUBST_LEN_W-1:0] subst_len,
    input  logic                   q_full,
    output logic                   q_push,
    output job_t                   q_job
);

    logic                  in_seq_reg, in_seq_next;
    logic [2:0]            exp_w_reg, exp_w_next;
    logic [2:0]            seen_reg, seen_next;
    logic [7:0]            pend_reg [PEND_DEPTH];

    logic                  pend_we;
    logic [PEND_IDX_W-1:0] pend_idx;
    logic                  accept;
    logic                  cont;
    logic                  fresh;
    logic [2:0]            w;
    logic [3:0]            seen_inc;
    logic [7:0]            b;
    job_t                  job;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign b        = in_data.data_byte;
    assign cont     = (b[7:6] == 2'b10);
    assign w        = lead_width(b);
    assign seen_inc = {1'b0, seen_reg} + 4'd1;

    // Classify the byte against the open sequence
    always_comb
    begin
        in_seq_next = in_seq_reg;
        exp_w_next  = exp_w_reg;
        seen_next   = seen_reg;
        pend_we     = 1'b0;
        pend_idx    = seen_reg;
        fresh       = 1'b0;
        job         = '0;

        if (in_seq_reg)
        begin
            if (!cont)
            begin
                // broken sequence: replace, then treat byte as new
                job.pre_repl = 1'b1;
                in_seq_next  = 1'b0;
                exp_w_next   = 3'd0;
                seen_next    = 3'd0;
                fresh        = 1'b1;
            end
            else if (seen_inc >= {1'b0, exp_w_reg})
            begin
                // sequence complete: release held bytes plus this one
                job.n_bytes = seen_inc[2:0];
                for (int i = 0; i < PEND_DEPTH; i++)
                begin
                    job.bytes[i] = (3'(i) < seen_reg) ? pend_reg[i] : b;
                end
                job.bytes[SEQ_BYTES-1] = b;
                in_seq_next = 1'b0;
                exp_w_next  = 3'd0;
                seen_next   = 3'd0;
            end
            else
            begin
                pend_we   = 1'b1;
                seen_next = seen_inc[2:0];
            end
        end
        else
        begin
            fresh = 1'b1;
        end

        if (fresh)
        begin
            priority if (w > 3'd1)
            begin
                pend_we     = 1'b1;
                pend_idx    = '0;
                seen_next   = 3'd1;
                exp_w_next  = w;
                in_seq_next = 1'b1;
            end
            else if (w == 3'd1)
            begin
                job.n_bytes  = 3'd1;
                job.bytes[0] = b;
            end
            else
            begin
                job.post_repl = 1'b1;
            end
        end

        // end of text drops any open sequence
        if (in_data.end_of_text)
        begin
            in_seq_next = 1'b0;
            exp_w_next  = 3'd0;
            seen_next   = 3'd0;
        end
    end

    // Only transactions that produce output go to the queue
    assign q_push = accept &&
                    ((((job.pre_repl || job.post_repl) && (subst_len != '0))) ||
                     (job.n_bytes != 3'd0));
    assign q_job  = job;

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg <= 1'b0;
            exp_w_reg  <= 3'd0;
            seen_reg   <= 3'd0;
        end
        else if (accept)
        begin
            in_seq_reg <= in_seq_next;
            exp_w_reg  <= exp_w_next;
            seen_reg   <= seen_next;
        end
    end

    // Held bytes of the open sequence
    always_ff @(posedge clk)
    begin
        if (accept && pend_we)
        begin
            pend_reg[pend_idx] <= b;
        end
    end

endmodule

[sv/u8san_queue.sv]
`timescale 1ns / 1ps

module u8san_queue
    import u8san_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/u8san_back.sv]
`timescale 1ns / 1ps

module u8san_back
    import u8san_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  job_t                      head_job,
    output logic                      pop,
    input  logic [CFG_DATA_W-1:0]     repl_bytes,
    input  logic [SUBST_LEN_W-1:0]    subst_len,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data
);

    phase_t     phase_reg, phase_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    phase_t     eff;
    logic [2:0] pre_n, body_n, post_n, seg_n;
    logic       later;
    logic       last_in_seg;
    logic       job_done;
    logic       fire;
    logic [7:0] cur_byte;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign pre_n  = head_job.pre_repl  ? subst_len : 3'd0;
    assign body_n = head_job.n_bytes;
    assign post_n = head_job.post_repl ? subst_len : 3'd0;
    assign fire   = head_valid && (!out_valid_reg || !out_stall);

    // Emit one byte per cycle from the head transaction while out_stall is low
    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;

        // skip empty segments
        unique case (phase_reg)
            PH_PRE:
            begin
                if (pre_n != 3'd0)       eff = PH_PRE;
                else if (body_n != 3'd0) eff = PH_BODY;
                else                     eff = PH_POST;
            end
            PH_BODY:
            begin
                eff = (body_n != 3'd0) ? PH_BODY : PH_POST;
            end
            default:
            begin
                eff = PH_POST;
            end
        endcase

        unique case (eff)
            PH_PRE:
            begin
                seg_n    = pre_n;
                later    = (body_n != 3'd0) || (post_n != 3'd0);
                cur_byte = repl_bytes[8*idx_reg[1:0] +: 8];
            end
            PH_BODY:
            begin
                seg_n    = body_n;
                later    = (post_n != 3'd0);
                cur_byte = head_job.bytes[idx_reg];
            end
            default:
            begin
                seg_n    = post_n;
                later    = 1'b0;
                cur_byte = repl_bytes[8*idx_reg[1:0] +: 8];
            end
        endcase

        last_in_seg = ((idx_reg + 3'd1) == seg_n);
        job_done    = last_in_seg && !later;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = cur_byte;
            out_next.last_of_run = job_done;
            if (job_done)
            begin
                pop        = 1'b1;
                phase_next = PH_PRE;
                idx_next   = 3'd0;
            end
            else if (last_in_seg)
            begin
                phase_next = (eff == PH_PRE) ? PH_BODY : PH_POST;
                idx_next   = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
